// ===== hw/rtl/bitmap_find_first_zero_engine_defines.svh =====
// Assertion macros for the bitmap engine RTL.
`ifndef BITMAP_FIND_FIRST_ZERO_ENGINE_DEFINES_SVH
`define BITMAP_FIND_FIRST_ZERO_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFZ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap engine check failed");

`endif

// ===== hw/rtl/bfz_pkg.sv =====
`timescale 1ns / 1ps

package bfz_pkg;

  // Default geometry of the bitmap.
  localparam int unsigned WORDS_DEFAULT     = 64;
  localparam int unsigned WORD_BITS_DEFAULT = 64;

  // Fixed field widths.
  localparam int unsigned OP_W  = 2;
  localparam int unsigned IDX_W = 12;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned POS_W = 12;

  // Request codes.
  typedef enum logic [OP_W-1:0] {
    OP_GET   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_FIND  = 2'd3
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_WR,
    ST_SCAN,
    ST_RESULT
  } state_e;

  // One result item.
  typedef struct packed {
    logic             bit_value;
    logic             found;
    logic [POS_W-1:0] zero_position;
  } bfz_result_t;

  // Priority encoder: position of the lowest set bit (0 when none is set).
  function automatic logic [5:0] lowest_one(input logic [63:0] vec);
    logic [5:0] pos;
    pos = '0;
    for (int i = 63; i >= 0; i--) begin
      if (vec[i]) begin
        pos = 6'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== hw/rtl/bitmap_find_first_zero_engine.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    operation_i, bit_index_i, search_words_i
// out      output     out_valid_o / out_stall_i  bit_value_o, found_o, zero_position_o
//
// Get, set and clear go through a reciprocal multiply for the word index, then a read of the word
// and, for set and clear, a write back of the word.
// Find reads the N words scanned, one memory read per cycle.
// After reset the bitmap is cleared one word per cycle; no request
// is taken until then. A result waiting under out_stall_i does not block the next
// request; that request finishes once the output register frees up.

module bitmap_find_first_zero_engine import bfz_pkg::*; #(
  parameter int unsigned WORDS     = WORDS_DEFAULT,
  parameter int unsigned WORD_BITS = WORD_BITS_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [OP_W-1:0]  operation_i,
  input  logic [IDX_W-1:0] bit_index_i,
  input  logic [CNT_W-1:0] search_words_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             bit_value_o,
  output logic             found_o,
  output logic [POS_W-1:0] zero_position_o
);

  localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic                 in_ready;
  logic                 res_valid;
  logic                 res_ready;
  bfz_result_t          res;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;
  logic                 out_valid_q;
  bfz_result_t          out_q;

  bfz_ctrl #(
    .WORDS     (WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready),
    .operation_i    (operation_i),
    .bit_index_i    (bit_index_i),
    .search_words_i (search_words_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  bfz_mem #(
    .WORDS     (WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = !in_ready;

  // Output register: loads when empty or when its result transfers this cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign bit_value_o     = out_q.bit_value;
  assign found_o         = out_q.found;
  assign zero_position_o = out_q.zero_position;

endmodule

// ===== hw/rtl/bfz_mem.sv =====
`timescale 1ns / 1ps

module bfz_mem import bfz_pkg::*; #(
  parameter int unsigned WORDS     = WORDS_DEFAULT,
  parameter int unsigned WORD_BITS = WORD_BITS_DEFAULT,
  localparam int unsigned AW       = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bfz_ctrl.sv =====
`timescale 1ns / 1ps
`include "bitmap_find_first_zero_engine_defines.svh"

module bfz_ctrl import bfz_pkg::*; #(
  parameter int unsigned WORDS     = WORDS_DEFAULT,
  parameter int unsigned WORD_BITS = WORD_BITS_DEFAULT,
  localparam int unsigned AW       = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Request side.
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [IDX_W-1:0]     bit_index_i,
  input  logic [CNT_W-1:0]     search_words_i,
  // Result side.
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output bfz_result_t          res_o,
  // Memory ports.
  output logic                 mem_we_o,
  output logic [AW-1:0]        mem_waddr_o,
  output logic [WORD_BITS-1:0] mem_wdata_o,
  output logic                 mem_re_o,
  output logic [AW-1:0]        mem_raddr_o,
  input  logic [WORD_BITS-1:0] mem_rdata_i
);

  localparam int unsigned BW      = $clog2(WORD_BITS);
  localparam int unsigned LIM_W   = ($clog2(WORDS + 1) > CNT_W) ? $clog2(WORDS + 1) : CNT_W;
  localparam int unsigned QW      = 10;
  localparam int unsigned RSH     = 24;
  localparam int unsigned RCP_W   = 22;
  // Reciprocal of the word size, exact for every 12-bit index.
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((1 << RSH) / WORD_BITS + 1);
  localparam logic [AW-1:0]    CLR_LAST = AW'(WORDS - 1);

  state_e               state_q, state_d;
  logic [AW-1:0]        clr_q;
  op_e                  op_q;
  logic [IDX_W-1:0]     idx_q;
  logic [QW-1:0]        q_q;
  logic [BW-1:0]        b_q;
  logic [LIM_W-1:0]     limit_q;
  logic [LIM_W-1:0]     scan_q;
  logic                 pend_q;
  logic [POS_W-1:0]     base_q;
  bfz_result_t          res_q;

  logic [LIM_W-1:0]     count_ext;
  logic [LIM_W-1:0]     limit_in;
  logic [IDX_W+RCP_W-1:0] recip_prod;
  logic [16:0]          q_mul;
  logic [IDX_W-1:0]     rem_full;
  logic                 q_oob;
  logic                 issue;
  logic                 word_full;
  logic [63:0]          inv_word;
  logic [5:0]           zero_bit;
  logic [WORD_BITS-1:0] bit_mask;
  logic                 accept;

  // Saturate the search count to the bitmap depth.
  assign count_ext = LIM_W'(search_words_i);
  assign limit_in  = (count_ext > LIM_W'(WORDS)) ? LIM_W'(WORDS) : count_ext;

  // Word index by reciprocal multiplication, bit offset from the registered quotient.
  assign recip_prod = idx_q * RECIP;
  assign q_mul      = q_q * 7'(WORD_BITS);
  assign rem_full   = idx_q - q_mul[IDX_W-1:0];
  assign q_oob      = ({1'b0, q_q} >= (QW + 1)'(WORDS));

  // Scan pipeline: issue one read per cycle, check the word read in the cycle before.
  assign issue     = (scan_q < limit_q);
  assign word_full = (mem_rdata_i == '1);
  assign inv_word  = 64'(~mem_rdata_i);
  assign zero_bit  = lowest_one(inv_word);
  assign bit_mask  = WORD_BITS'(1) << b_q;
  assign accept    = in_valid_i && (state_q == ST_IDLE);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (op_e'(operation_i) == OP_FIND) begin
            state_d = (limit_in == '0) ? ST_RESULT : ST_SCAN;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV:  state_d = ST_RD;
      ST_RD:   state_d = q_oob ? ST_RESULT : ST_WR;
      ST_WR:   state_d = ST_RESULT;
      ST_SCAN: begin
        if (pend_q && (!word_full || !issue)) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Output and memory-port decode.
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = q_q[AW-1:0];
    mem_wdata_o = mem_rdata_i | bit_mask;
    mem_re_o    = 1'b0;
    mem_raddr_o = q_q[AW-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
      end
      ST_IDLE:   in_ready_o = 1'b1;
      ST_DIV:    ;
      ST_RD:     mem_re_o = !q_oob;
      ST_WR: begin
        mem_we_o = (op_q == OP_SET) || (op_q == OP_CLEAR);
        if (op_q == OP_CLEAR) begin
          mem_wdata_o = mem_rdata_i & ~bit_mask;
        end
      end
      ST_SCAN: begin
        mem_re_o    = issue;
        mem_raddr_o = scan_q[AW-1:0];
      end
      ST_RESULT: res_valid_o = 1'b1;
      default:   ;
    endcase
  end

  assign res_o = res_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  // Request and result datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_q    <= op_e'(operation_i);
          idx_q   <= bit_index_i;
          limit_q <= limit_in;
          scan_q  <= '0;
          pend_q  <= 1'b0;
          base_q  <= '0;
          res_q   <= '0;
        end
      end
      ST_DIV: q_q <= recip_prod[RSH +: QW];
      ST_RD:  b_q <= rem_full[BW-1:0];
      ST_WR:  res_q.bit_value <= mem_rdata_i[b_q];
      ST_SCAN: begin
        scan_q <= scan_q + LIM_W'(issue);
        pend_q <= issue;
        if (pend_q) begin
          if (!word_full) begin
            res_q.found         <= 1'b1;
            res_q.zero_position <= base_q + POS_W'(zero_bit);
          end else begin
            base_q <= base_q + POS_W'(WORD_BITS);
          end
        end
      end
      default: ;
    endcase
  end

  // The bitmap is written only by the clearing pass or by set and clear requests.
  `BFZ_ASSERT_NOW(a_write_op, clk_i, rst_ni,
                  mem_we_o && (state_q != ST_CLEAR),
                  (op_q == OP_SET) || (op_q == OP_CLEAR))
  // Only a find request can report a located zero.
  `BFZ_ASSERT_NOW(a_found_find, clk_i, rst_ni, res_valid_o && res_o.found, op_q == OP_FIND)
  // The scan never runs past the saturated count.
  `BFZ_ASSERT_NOW(a_scan_limit, clk_i, rst_ni, state_q == ST_SCAN,
                  (scan_q <= limit_q) && (limit_q <= LIM_W'(WORDS)))
  // An accepted request holds off the next one.
  `BFZ_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, accept, !in_ready_o)

endmodule
